[hw/rtl/can_nominal_bit_timing_unit_assert.svh]
// Assertion macros for the checker file of the bit timing unit.
`ifndef CAN_NOMINAL_BIT_TIMING_UNIT_ASSERT_SVH
`define CAN_NOMINAL_BIT_TIMING_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CNBT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CNBT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/cnbt_pkg.sv]
// Types and constants of the CAN nominal bit timing unit.
`default_nettype none

package cnbt_pkg;

   localparam int CLOCK_HZ_W    = 30;
   localparam int BIT_RATE_W    = 24;
   localparam int PRESCALER_W   = 10;
   localparam int SEGMENT_ONE_W = 9;
   localparam int SEGMENT_TWO_W = 8;
   localparam int TIMING_WORD_W = 32;
   localparam int STATUS_W      = 2;

   localparam logic [CLOCK_HZ_W-1:0] CLOCK_HZ_RESET = 30'd170000000;

   localparam int MAX_CLOCKS_PER_BIT = 384;
   localparam int PRESCALER_LIMIT    = 512;
   localparam int SEG_TWO_MAX        = 128;
   localparam int MIN_BIT_CLOCKS     = 3;
   localparam int SEG_DIVISOR        = 3;

   // Serial multiplier: the multiplier operand holds MAX_CLOCKS_PER_BIT + 1 or a prescaler.
   localparam int MPLIER_W   = 11;
   localparam int PRODUCT_W  = BIT_RATE_W + MPLIER_W;
   localparam int MUL_STEPS  = MPLIER_W;
   // Serial divider: one quotient bit per cycle over the clock word.
   localparam int DIV_STEPS  = CLOCK_HZ_W;
   localparam int STEP_CNT_W = 5;
   // Clocks per bit never exceed MAX_CLOCKS_PER_BIT.
   localparam int CLOCKS_W   = 9;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK          = 2'd0,
      STATUS_ZERO_RATE   = 2'd1,
      STATUS_LOW_CLOCKS  = 2'd2,
      STATUS_PRESC_LIMIT = 2'd3
   } status_type;

endpackage

`default_nettype wire

[hw/rtl/cnbt_channels.sv]
// Valid/ready channel interfaces for requests and responses of the bit timing unit.
`default_nettype none

interface cnbt_req_if;
   import cnbt_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [BIT_RATE_W-1:0] bit_rate;

   modport source (output valid, output bit_rate, input ready);
   modport sink (input valid, input bit_rate, output ready);
endinterface

interface cnbt_rsp_if;
   import cnbt_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [PRESCALER_W-1:0]   prescaler;
   logic [SEGMENT_ONE_W-1:0] segment_one;
   logic [SEGMENT_TWO_W-1:0] segment_two;
   logic [SEGMENT_TWO_W-1:0] jump_width;
   logic [TIMING_WORD_W-1:0] timing_word;
   status_type               status;

   modport source (output valid, output prescaler, output segment_one, output segment_two,
                   output jump_width, output timing_word, output status, input ready);
   modport sink (input valid, input prescaler, input segment_one, input segment_two,
                 input jump_width, input timing_word, input status, output ready);
endinterface

`default_nettype wire

[hw/rtl/can_nominal_bit_timing_unit.sv]
// CAN nominal bit timing unit: prescaler and segment search for a requested bit rate.
//
// A request on req_chan carries a bit rate in bits per second. The unit derives the
// smallest prescaler within MAX_CLOCKS_PER_BIT clocks per bit from the peripheral clock
// held in the csr register, splits the bit into sync, segment one and segment two,
// and returns one response on rsp_chan with the fields, the packed timing word and
// a status code. The user must write the csr register only while no request is in
// flight; the unit itself does not enforce this. A full request runs two serial
// shift-add multiplications and three restoring divisions, all on one shared
// bit-serial datapath, and then loads the response. A zero rate goes straight to
// the response, a prescaler overflow ends after the first division and too few
// clocks per bit end after the second division.
// The unit works on one request at a time; req_chan.ready is high only while it
// is idle, so a new request is accepted only once the previous one has left the
// datapath. The response register is separate from the datapath, so a new request
// is accepted while the previous response still waits; a finished result waits
// in the final step until the response register is free.
// Reset is synchronous and active high. It empties the sequencer and the response
// register and returns the clock register to 170 MHz.
`default_nettype none

module can_nominal_bit_timing_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   cnbt_req_if.sink                           req_chan,
   cnbt_rsp_if.source                         rsp_chan,
   input  wire logic                          csr_wr_en,
   input  wire logic [cnbt_pkg::CLOCK_HZ_W-1:0] csr_wr_data
);
   import cnbt_pkg::*;

   // One-hot sequencer. Each state between idle and finish runs one serial operation.
   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_MUL_LIMIT = 7'b0000010,
      ST_DIV_LIMIT = 7'b0000100,
      ST_MUL_BIT   = 7'b0001000,
      ST_DIV_BIT   = 7'b0010000,
      ST_DIV_SEG   = 7'b0100000,
      ST_FINISH    = 7'b1000000
   } state_type;

   state_type               state_ff, state_in;
   logic [STEP_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CLOCK_HZ_W-1:0]   clock_hz_ff, clock_hz_in;
   logic [BIT_RATE_W-1:0]   rate_ff, rate_in;
   logic [PRODUCT_W-1:0]    mcand_ff, mcand_in;
   logic [MPLIER_W-1:0]     mplier_ff, mplier_in;
   // Product accumulator, which then serves as the divisor.
   logic [PRODUCT_W-1:0]    dsr_ff, dsr_in;
   // Dividend shifts out at the top while quotient bits shift in at the bottom.
   logic [CLOCK_HZ_W-1:0]   dvd_ff, dvd_in;
   logic [PRODUCT_W-1:0]    rem_ff, rem_in;
   logic [PRESCALER_W-1:0]  presc_ff, presc_in;
   logic [CLOCKS_W-1:0]     clocks_ff, clocks_in;
   status_type              status_ff, status_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [PRESCALER_W-1:0]   rsp_presc_ff, rsp_presc_in;
   logic [SEGMENT_ONE_W-1:0] rsp_seg1_ff, rsp_seg1_in;
   logic [SEGMENT_TWO_W-1:0] rsp_seg2_ff, rsp_seg2_in;
   logic [TIMING_WORD_W-1:0] rsp_word_ff, rsp_word_in;
   status_type               rsp_status_ff, rsp_status_in;

   logic                    req_fire;
   logic                    step_last;
   logic [PRODUCT_W-1:0]    mul_acc;
   logic [PRODUCT_W:0]      div_shifted;
   logic [PRODUCT_W+1:0]    div_diff;
   logic                    div_fits;
   logic [PRODUCT_W-1:0]    div_rem;
   logic [CLOCK_HZ_W-1:0]   div_quot;
   logic [CLOCKS_W-1:0]     seg_quot;
   logic [SEGMENT_TWO_W-1:0] seg_two;
   logic [SEGMENT_ONE_W-1:0] seg_one;
   logic [PRESCALER_W-1:0]  presc_m1;
   logic [SEGMENT_ONE_W-1:0] seg_one_m1;
   logic [SEGMENT_TWO_W-1:0] seg_two_m1;
   logic                    rsp_free;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   // Shift-add step: add the shifted multiplicand when the current multiplier bit is set.
   assign mul_acc = mplier_ff[0] ? (dsr_ff + mcand_ff) : dsr_ff;

   // Restoring division step: one quotient bit per cycle.
   assign div_shifted = {rem_ff, dvd_ff[CLOCK_HZ_W-1]};
   assign div_diff    = {1'b0, div_shifted} - {2'b00, dsr_ff};
   assign div_fits    = !div_diff[PRODUCT_W+1];
   assign div_rem     = div_fits ? div_diff[PRODUCT_W-1:0] : div_shifted[PRODUCT_W-1:0];
   assign div_quot    = {dvd_ff[CLOCK_HZ_W-2:0], div_fits};

   // Segment two is a third of the quanta after sync, clamped to its legal range.
   assign seg_quot = dvd_ff[CLOCKS_W-1:0];
   always_comb begin
      priority if (seg_quot > CLOCKS_W'(SEG_TWO_MAX)) begin
         seg_two = SEGMENT_TWO_W'(SEG_TWO_MAX);
      end else if (seg_quot == '0) begin
         seg_two = SEGMENT_TWO_W'(1);
      end else begin
         seg_two = seg_quot[SEGMENT_TWO_W-1:0];
      end
   end
   assign seg_one    = clocks_ff - SEGMENT_ONE_W'(1) - {1'b0, seg_two};
   assign presc_m1   = presc_ff - PRESCALER_W'(1);
   assign seg_one_m1 = seg_one - SEGMENT_ONE_W'(1);
   assign seg_two_m1 = seg_two - SEGMENT_TWO_W'(1);

   assign step_last = (state_ff == ST_MUL_LIMIT || state_ff == ST_MUL_BIT)
                      ? (cnt_ff == STEP_CNT_W'(MUL_STEPS - 1))
                      : (cnt_ff == STEP_CNT_W'(DIV_STEPS - 1));

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      clock_hz_in   = csr_wr_en ? csr_wr_data : clock_hz_ff;
      rate_in       = rate_ff;
      mcand_in      = mcand_ff;
      mplier_in     = mplier_ff;
      dsr_in        = dsr_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      presc_in      = presc_ff;
      clocks_in     = clocks_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_presc_in  = rsp_presc_ff;
      rsp_seg1_in   = rsp_seg1_ff;
      rsp_seg2_in   = rsp_seg2_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rate_in   = req_chan.bit_rate;
               mcand_in  = PRODUCT_W'(req_chan.bit_rate);
               mplier_in = MPLIER_W'(MAX_CLOCKS_PER_BIT + 1);
               dsr_in    = '0;
               cnt_in    = '0;
               if (req_chan.bit_rate == '0) begin
                  status_in = STATUS_ZERO_RATE;
                  state_in  = ST_FINISH;
               end else begin
                  status_in = STATUS_OK;
                  state_in  = ST_MUL_LIMIT;
               end
            end
         end
         ST_MUL_LIMIT, ST_MUL_BIT: begin
            dsr_in    = mul_acc;
            mcand_in  = {mcand_ff[PRODUCT_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[MPLIER_W-1:1]};
            cnt_in    = cnt_ff + STEP_CNT_W'(1);
            if (step_last) begin
               cnt_in   = '0;
               dvd_in   = clock_hz_ff;
               rem_in   = '0;
               state_in = (state_ff == ST_MUL_LIMIT) ? ST_DIV_LIMIT : ST_DIV_BIT;
            end
         end
         ST_DIV_LIMIT: begin
            dvd_in = div_quot;
            rem_in = div_rem;
            cnt_in = cnt_ff + STEP_CNT_W'(1);
            if (step_last) begin
               cnt_in = '0;
               if (div_quot >= CLOCK_HZ_W'(PRESCALER_LIMIT)) begin
                  status_in = STATUS_PRESC_LIMIT;
                  state_in  = ST_FINISH;
               end else begin
                  presc_in  = div_quot[PRESCALER_W-1:0] + PRESCALER_W'(1);
                  mcand_in  = PRODUCT_W'(rate_ff);
                  mplier_in = MPLIER_W'(div_quot[PRESCALER_W-1:0] + PRESCALER_W'(1));
                  dsr_in    = '0;
                  state_in  = ST_MUL_BIT;
               end
            end
         end
         ST_DIV_BIT: begin
            dvd_in = div_quot;
            rem_in = div_rem;
            cnt_in = cnt_ff + STEP_CNT_W'(1);
            if (step_last) begin
               cnt_in = '0;
               if (div_quot < CLOCK_HZ_W'(MIN_BIT_CLOCKS)) begin
                  status_in = STATUS_LOW_CLOCKS;
                  state_in  = ST_FINISH;
               end else begin
                  // The quanta after the sync segment are divided by three next.
                  clocks_in = div_quot[CLOCKS_W-1:0];
                  dvd_in    = CLOCK_HZ_W'(div_quot[CLOCKS_W-1:0] - CLOCKS_W'(1));
                  rem_in    = '0;
                  dsr_in    = PRODUCT_W'(SEG_DIVISOR);
                  state_in  = ST_DIV_SEG;
               end
            end
         end
         ST_DIV_SEG: begin
            dvd_in = div_quot;
            rem_in = div_rem;
            cnt_in = cnt_ff + STEP_CNT_W'(1);
            if (step_last) begin
               cnt_in   = '0;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hold the result until the response register can take it.
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               if (status_ff == STATUS_OK) begin
                  rsp_presc_in = presc_ff;
                  rsp_seg1_in  = seg_one;
                  rsp_seg2_in  = seg_two;
                  rsp_word_in  = {seg_two[6:0], presc_m1[8:0], seg_one_m1[7:0],
                                  1'b0, seg_two_m1[6:0]};
               end else begin
                  rsp_presc_in = '0;
                  rsp_seg1_in  = '0;
                  rsp_seg2_in  = '0;
                  rsp_word_in  = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         clock_hz_ff  <= CLOCK_HZ_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         clock_hz_ff  <= clock_hz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rate_ff       <= rate_in;
      mcand_ff      <= mcand_in;
      mplier_ff     <= mplier_in;
      dsr_ff        <= dsr_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      presc_ff      <= presc_in;
      clocks_ff     <= clocks_in;
      status_ff     <= status_in;
      rsp_presc_ff  <= rsp_presc_in;
      rsp_seg1_ff   <= rsp_seg1_in;
      rsp_seg2_ff   <= rsp_seg2_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.prescaler   = rsp_presc_ff;
   assign rsp_chan.segment_one = rsp_seg1_ff;
   assign rsp_chan.segment_two = rsp_seg2_ff;
   assign rsp_chan.jump_width  = rsp_seg2_ff;
   assign rsp_chan.timing_word = rsp_word_ff;
   assign rsp_chan.status      = rsp_status_ff;

endmodule

`default_nettype wire

[hw/rtl/cnbt_checker.sv]
// Port-level checker of the bit timing unit and its bind to the top level.
`default_nettype none

`include "can_nominal_bit_timing_unit_assert.svh"

module cnbt_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_ready,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic [cnbt_pkg::PRESCALER_W-1:0]   rsp_prescaler,
   input wire logic [cnbt_pkg::SEGMENT_TWO_W-1:0] rsp_segment_two,
   input wire logic [cnbt_pkg::SEGMENT_TWO_W-1:0] rsp_jump_width,
   input wire logic [cnbt_pkg::TIMING_WORD_W-1:0] rsp_timing_word,
   input wire logic [cnbt_pkg::STATUS_W-1:0]      rsp_status
);
   import cnbt_pkg::*;

   // The unit works on one request at a time, so it is busy right after an accept.
   `CNBT_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready,
                     "ready stayed high after a request was accepted")

   // A stalled response keeps its payload.
   `CNBT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_timing_word) && $stable(rsp_status),
                     "stalled response changed")

   // Error responses carry no timing.
   `CNBT_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid && (rsp_status != STATUS_OK),
                    (rsp_prescaler == '0) && (rsp_timing_word == '0),
                    "error response carries timing fields")

   // Good responses have the jump width equal to a nonzero segment two.
   `CNBT_ASSERT_NOW(a_ok_sjw, clock, reset, rsp_valid && (rsp_status == STATUS_OK),
                    (rsp_jump_width == rsp_segment_two) && (rsp_segment_two != '0),
                    "jump width differs from segment two")

   // Good responses stay within the prescaler limit.
   `CNBT_ASSERT_NOW(a_ok_presc, clock, reset, rsp_valid && (rsp_status == STATUS_OK),
                    (rsp_prescaler != '0) && (rsp_prescaler <= PRESCALER_W'(PRESCALER_LIMIT)),
                    "prescaler out of range")

endmodule

bind can_nominal_bit_timing_unit cnbt_checker u_cnbt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_prescaler   (rsp_chan.prescaler),
   .rsp_segment_two (rsp_chan.segment_two),
   .rsp_jump_width  (rsp_chan.jump_width),
   .rsp_timing_word (rsp_chan.timing_word),
   .rsp_status      (rsp_chan.status)
);

`default_nettype wire
